// ----- src/multidim_line_address_generator_defines.svh -----
// assertion macros for the multidimensional line address generator
`ifndef MULTIDIM_LINE_ADDRESS_GENERATOR_DEFINES_SVH
`define MULTIDIM_LINE_ADDRESS_GENERATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MLAG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlag assertion failed");

// antecedent implies consequent in the next cycle
`define MLAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlag assertion failed");

`endif

// ----- src/mlag_pkg.sv -----
// package for the multidimensional line address generator: constants and state type
`default_nettype none

package mlag_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int OFS_W       = 32;
  localparam int SIZE_W      = 16;
  localparam int AX_W        = $clog2(MAX_DIMS);
  localparam int AXC_W       = AX_W + 1;

  localparam logic [2:0] REG_DIM_COUNT      = 3'd0;
  localparam logic [2:0] REG_SKIP_AXIS      = 3'd1;
  localparam logic [2:0] REG_ELEMENT_STRIDE = 3'd2;
  localparam logic [2:0] REG_START_OFFSET   = 3'd3;
  localparam logic [2:0] REG_DIM_SIZE_0     = 3'd4;
  localparam logic [2:0] REG_DIM_SIZE_1     = 3'd5;
  localparam logic [2:0] REG_DIM_SIZE_2     = 3'd6;
  localparam logic [2:0] REG_DIM_SIZE_3     = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_PROD,
    ST_LOAD,
    ST_ADV,
    ST_WRAP_MUL,
    ST_WRAP_SUB
  } state_t;

endpackage

`default_nettype wire

// ----- src/multidim_line_address_generator.sv -----
// top level of the multidimensional line address generator
//
// input channel s_*: one transfer is one request; s_tdata[0] = restart.
// a restart recomputes the per-axis strides, clears the digit counters and
// loads start_offset before the request is answered.
// output channel m_*: one transfer per request; tdata holds base_offset,
// line_stride and line_length, tlast marks the final line of the walk and
// tuser flags an exhausted walk (tdata and tlast are zero then).
// configuration channel cfg_*: register index and data, always ready; write
// only while no request is in flight.
// one shared 32x16 multiplier under a small sequencer does all the work:
// a restart forms the stride and running product of each used axis in turn
// (ST_STRIDE, ST_PROD) and zeroes unused strides; an answer loads the result
// (ST_LOAD) and, unless the walk is exhausted, steps the digit counters from
// axis 0 up (ST_ADV) to the first that does not wrap, or one past the top.
// one request is worked on at a time: s_tready is low while a request runs
// and while its result waits in the output register, so a stalled receiver
// holds the block.
// reset (rst, synchronous) restores the register defaults and leaves the walk
// exhausted until the next restart.
`default_nettype none
`include "multidim_line_address_generator_defines.svh"

module multidim_line_address_generator
  import mlag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // restart
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // base_offset, line_stride, line_length
  output logic             m_tlast,   // last_line
  output logic             m_tuser    // exhausted
);

  // configuration registers
  logic [2:0]        dim_count;
  logic [AX_W-1:0]   skip_axis;
  logic [SIZE_W-1:0] element_stride;
  logic [OFS_W-1:0]  start_offset;
  logic [SIZE_W-1:0] dim_size [MAX_DIMS];

  // walk state
  state_t            state, state_next;
  logic [SIZE_W-1:0] digit_cnt [MAX_DIMS];
  logic [OFS_W-1:0]  axis_stride [MAX_DIMS];
  logic [OFS_W-1:0]  cur_offset;
  logic              walk_done;
  logic [OFS_W-1:0]  prod;
  logic [OFS_W-1:0]  mul_q;
  logic [AXC_W-1:0]  ax;

  // result register
  logic [OFS_W-1:0]  res_base;
  logic [OFS_W-1:0]  res_stride;
  logic [SIZE_W-1:0] res_len;
  logic              res_last;
  logic              res_exh;

  // combinational
  logic              in_xfer;
  logic [AXC_W-1:0]  n_used;
  logic [SIZE_W-1:0] sz_ax;
  logic [SIZE_W-1:0] sz_skip;
  logic [SIZE_W:0]   cnt_inc;
  logic              ax_in_use;
  logic              ax_skip;
  logic              ax_wrap;
  logic              finish;
  logic              skip_valid;
  logic [OFS_W-1:0]  mul_a;
  logic [SIZE_W-1:0] mul_b;
  logic [OFS_W+SIZE_W-1:0] mul_p;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;

  always_comb begin
    n_used     = (dim_count > 3'(MAX_DIMS)) ? AXC_W'(MAX_DIMS) : AXC_W'(dim_count);
    sz_ax      = (dim_size[ax[AX_W-1:0]] == '0) ? SIZE_W'(1) : dim_size[ax[AX_W-1:0]];
    sz_skip    = (dim_size[skip_axis] == '0) ? SIZE_W'(1) : dim_size[skip_axis];
    cnt_inc    = {1'b0, digit_cnt[ax[AX_W-1:0]]} + (SIZE_W+1)'(1);
    ax_in_use  = ax < n_used;
    ax_skip    = ax[AX_W-1:0] == skip_axis;
    ax_wrap    = cnt_inc >= {1'b0, sz_ax};
    skip_valid = {1'b0, skip_axis} < n_used;
  end

  // shared multiplier operand selection
  always_comb begin
    case (state)
      ST_STRIDE: begin
        mul_a = prod;
        mul_b = element_stride;
      end
      ST_PROD: begin
        mul_a = prod;
        mul_b = sz_ax;
      end
      ST_WRAP_MUL: begin
        mul_a = axis_stride[ax[AX_W-1:0]];
        mul_b = sz_ax - SIZE_W'(1);
      end
      default: begin
        mul_a = prod;
        mul_b = sz_ax;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = s_tdata[0] ? ST_STRIDE : ST_LOAD;
        end
      end
      ST_STRIDE: begin
        if (ax_in_use) begin
          state_next = ST_PROD;
        end else if (ax == AXC_W'(MAX_DIMS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_PROD: begin
        state_next = (ax == AXC_W'(MAX_DIMS - 1)) ? ST_LOAD : ST_STRIDE;
      end
      ST_LOAD: begin
        state_next = walk_done ? ST_IDLE : ST_ADV;
      end
      ST_ADV: begin
        if (!ax_in_use) begin
          state_next = ST_IDLE;
        end else if (ax_skip) begin
          state_next = ST_ADV;
        end else if (ax_wrap) begin
          state_next = ST_WRAP_MUL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WRAP_MUL: state_next = ST_WRAP_SUB;
      ST_WRAP_SUB: state_next = ST_ADV;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = (state == ST_IDLE) && !m_tvalid;
    case (state)
      ST_LOAD: finish = walk_done;
      ST_ADV:  finish = !ax_in_use || (!ax_skip && !ax_wrap);
      default: finish = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count      <= 3'd1;
      skip_axis      <= '0;
      element_stride <= SIZE_W'(1);
      start_offset   <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_size[i] <= SIZE_W'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIM_COUNT:      dim_count      <= cfg_data[2:0];
        REG_SKIP_AXIS:      skip_axis      <= cfg_data[AX_W-1:0];
        REG_ELEMENT_STRIDE: element_stride <= cfg_data[SIZE_W-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[OFS_W-1:0];
        REG_DIM_SIZE_0:     dim_size[0]    <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_1:     dim_size[1]    <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_2:     dim_size[2]    <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_3:     dim_size[3]    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      walk_done  <= 1'b1;
      cur_offset <= '0;
      ax         <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        digit_cnt[i]   <= '0;
        axis_stride[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && s_tdata[0]) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
              digit_cnt[i] <= '0;
            end
            cur_offset <= start_offset;
            walk_done  <= 1'b0;
            ax         <= '0;
          end
        end
        ST_STRIDE: begin
          if (ax_in_use) begin
            axis_stride[ax[AX_W-1:0]] <= mul_p[OFS_W-1:0];
          end else begin
            axis_stride[ax[AX_W-1:0]] <= '0;
            ax <= ax + AXC_W'(1);
          end
        end
        ST_PROD: begin
          ax <= ax + AXC_W'(1);
        end
        ST_LOAD: begin
          ax <= '0;
        end
        ST_ADV: begin
          if (!ax_in_use) begin
            walk_done <= 1'b1;
          end else if (ax_skip) begin
            ax <= ax + AXC_W'(1);
          end else if (ax_wrap) begin
            digit_cnt[ax[AX_W-1:0]] <= '0;
          end else begin
            digit_cnt[ax[AX_W-1:0]] <= cnt_inc[SIZE_W-1:0];
            cur_offset <= cur_offset + axis_stride[ax[AX_W-1:0]];
          end
        end
        ST_WRAP_SUB: begin
          cur_offset <= cur_offset - mul_q;
          ax <= ax + AXC_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        prod <= OFS_W'(1);
      end
      ST_PROD: begin
        prod <= mul_p[OFS_W-1:0];
      end
      ST_LOAD: begin
        if (walk_done) begin
          res_base   <= '0;
          res_stride <= '0;
          res_len    <= '0;
          res_last   <= 1'b0;
          res_exh    <= 1'b1;
        end else begin
          res_base <= cur_offset;
          res_exh  <= 1'b0;
          if (skip_valid) begin
            res_stride <= axis_stride[skip_axis];
            res_len    <= sz_skip;
          end else begin
            res_stride <= OFS_W'(element_stride);
            res_len    <= SIZE_W'(1);
          end
        end
      end
      ST_ADV: begin
        res_last <= !ax_in_use;
      end
      ST_WRAP_MUL: begin
        mul_q <= mul_p[OFS_W-1:0];
      end
      default: ;
    endcase
  end

  assign m_tdata = {res_len, res_stride, res_base};
  assign m_tlast = res_last;
  assign m_tuser = res_exh;

  `MLAG_ASSERT_SAME(a_ready_only_when_empty, clk, rst, s_tready, !m_tvalid && state == ST_IDLE)
  `MLAG_ASSERT_SAME(a_exhausted_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast)
  `MLAG_ASSERT_NEXT(a_one_result, clk, rst, m_tvalid && m_tready, !m_tvalid)
  `MLAG_ASSERT_NEXT(a_restart_seq, clk, rst, in_xfer && s_tdata[0], state == ST_STRIDE)

endmodule

`default_nettype wire
